// File: rtl/core/pfenc_pkg.sv
// Shared types, constants, letter helpers and the microcode store of the Playfair encryptor.
package pfenc_pkg;

  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int LETTERS = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;
  typedef logic [3:0] step_t;

  localparam letter_t LET_I    = 5'd8;
  localparam letter_t LET_J    = 5'd9;
  localparam letter_t LET_Q    = 5'd16;
  localparam letter_t LET_X    = 5'd23;
  localparam letter_t LET_LAST = letter_t'(LETTERS - 1);
  localparam cell_t   NCELLS   = cell_t'(CELLS);
  localparam letter_t NLETTERS = letter_t'(LETTERS);
  localparam coord_t  LAST_COORD = coord_t'(SIDE - 1);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_FINISH  = 2'd1,
    OP_ENCRYPT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    A_NOP,
    A_PLACE_KEY,
    A_VCLR,
    A_PLACE_V,
    A_FOLD,
    A_RD_LCA,
    A_RD_LCB,
    A_CAP_CB,
    A_CALC,
    A_RD_OA,
    A_RD_OB,
    A_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_DISPATCH,
    C_VLOOP,
    C_ENCCHK
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_ADD    = 4'd1;
  localparam step_t S_FIN    = 4'd2;
  localparam step_t S_FLOOP  = 4'd3;
  localparam step_t S_ENC    = 4'd4;
  localparam step_t S_RDA    = 4'd5;
  localparam step_t S_RDB    = 4'd6;
  localparam step_t S_CAPB   = 4'd7;
  localparam step_t S_CALC   = 4'd8;
  localparam step_t S_RDOA   = 4'd9;
  localparam step_t S_RDOB   = 4'd10;
  localparam step_t S_EMIT   = 4'd11;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{act: A_NOP, cond: C_GOTO, target: S_IDLE};
    unique case (s)
      S_IDLE:  w = '{act: A_NOP,       cond: C_DISPATCH, target: S_IDLE};
      S_ADD:   w = '{act: A_PLACE_KEY, cond: C_GOTO,     target: S_IDLE};
      S_FIN:   w = '{act: A_VCLR,      cond: C_NEXT,     target: S_IDLE};
      S_FLOOP: w = '{act: A_PLACE_V,   cond: C_VLOOP,    target: S_IDLE};
      S_ENC:   w = '{act: A_FOLD,      cond: C_ENCCHK,   target: S_IDLE};
      S_RDA:   w = '{act: A_RD_LCA,    cond: C_NEXT,     target: S_IDLE};
      S_RDB:   w = '{act: A_RD_LCB,    cond: C_NEXT,     target: S_IDLE};
      S_CAPB:  w = '{act: A_CAP_CB,    cond: C_NEXT,     target: S_IDLE};
      S_CALC:  w = '{act: A_CALC,      cond: C_NEXT,     target: S_IDLE};
      S_RDOA:  w = '{act: A_RD_OA,     cond: C_NEXT,     target: S_IDLE};
      S_RDOB:  w = '{act: A_RD_OB,     cond: C_NEXT,     target: S_IDLE};
      S_EMIT:  w = '{act: A_EMIT,      cond: C_GOTO,     target: S_IDLE};
      default: w = '{act: A_NOP,       cond: C_GOTO,     target: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic letter_t fold_letter(input letter_t v);
    return (v == LET_J) ? LET_I : v;
  endfunction

  function automatic coord_t cell_row(input cell_t c);
    coord_t r;
    if (c >= cell_t'(4 * SIDE)) r = 3'd4;
    else if (c >= cell_t'(3 * SIDE)) r = 3'd3;
    else if (c >= cell_t'(2 * SIDE)) r = 3'd2;
    else if (c >= cell_t'(SIDE)) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic cell_t row_base(input coord_t r);
    return cell_t'({r, 2'b00}) + cell_t'(r);
  endfunction

  function automatic coord_t cell_col(input cell_t c);
    cell_t d;
    d = c - row_base(cell_row(c));
    return d[2:0];
  endfunction

  function automatic coord_t wrap_inc(input coord_t k);
    return (k == LAST_COORD) ? 3'd0 : coord_t'(k + 3'd1);
  endfunction

  function automatic cell_t cell_at(input coord_t r, input coord_t k);
    return row_base(r) + cell_t'(k);
  endfunction

endpackage

// File: rtl/core/pfenc_ram.sv
// Generic single-write, single-read memory with registered read data.
module pfenc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/playfair_digraph_encrypt.sv
// Playfair encryptor top level: microcoded sequencer over key square and letter-to-cell memories.
// Add key letter: one placement step, then idle. Finish key: scans every letter, one per cycle.
// Encrypt pair: out_valid rises in the same cycle that busy goes low; a rejected pair returns
// to idle with no result. One lookup per memory port per cycle sets the step order. Items run one at a time.
// Reset (rst_n low, synchronous) empties the key square and returns the sequencer to idle.
// out_valid pulses one cycle per result and cannot be held off.
module playfair_digraph_encrypt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  pfenc_pkg::letter_t  in_first_letter,
  input  pfenc_pkg::letter_t  in_second_letter,
  output logic                out_valid,
  output pfenc_pkg::letter_t  out_cipher_first,
  output pfenc_pkg::letter_t  out_cipher_second
);

  import pfenc_pkg::*;

  step_t              pc_r, pc_nxt;
  cell_t              fill_r, fill_nxt;
  logic [LETTERS-1:0] placed_r, placed_nxt;
  letter_t            v_r, v_nxt;
  letter_t            a_r, a_nxt;
  letter_t            b_r, b_nxt;
  cell_t              ca_r, ca_nxt;
  cell_t              cb_r, cb_nxt;
  cell_t              oa_r, oa_nxt;
  cell_t              ob_r, ob_nxt;
  letter_t            cf_r, cf_nxt;
  logic               out_valid_r, out_valid_nxt;
  letter_t            out_first_r, out_first_nxt;
  letter_t            out_second_r, out_second_nxt;

  uword_t  uw;
  letter_t place_letter;
  logic    place_ok;
  logic    place_act;
  logic    enc_bad;
  letter_t fa, fb;
  coord_t  ra, ka, rb, kb;

  logic    ks_we, lc_re, ks_re;
  cell_t   lc_raddr, ks_raddr;
  cell_t   lc_rdata;
  letter_t ks_rdata;

  pfenc_ram #(.WIDTH(5), .DEPTH(CELLS)) u_key_square (
    .clk     (clk),
    .wr_en   (ks_we),
    .wr_addr (fill_r),
    .wr_data (place_letter),
    .rd_en   (ks_re),
    .rd_addr (ks_raddr),
    .rd_data (ks_rdata)
  );

  pfenc_ram #(.WIDTH(5), .DEPTH(LETTERS)) u_letter_cell (
    .clk     (clk),
    .wr_en   (ks_we),
    .wr_addr (place_letter),
    .wr_data (fill_r),
    .rd_en   (lc_re),
    .rd_addr (lc_raddr),
    .rd_data (lc_rdata)
  );

  assign uw = ucode(pc_r);

  assign place_act    = (uw.act == A_PLACE_KEY) || (uw.act == A_PLACE_V);
  assign place_letter = (uw.act == A_PLACE_V) ? v_r : fold_letter(a_r);
  assign place_ok     = place_act && (place_letter < NLETTERS) && !placed_r[place_letter]
                        && (fill_r < NCELLS) && !((uw.act == A_PLACE_V) && (v_r == LET_J));
  assign ks_we        = place_ok;

  assign lc_re    = (uw.act == A_RD_LCA) || (uw.act == A_RD_LCB);
  assign lc_raddr = (uw.act == A_RD_LCA) ? a_r : b_r;
  assign ks_re    = (uw.act == A_RD_OA) || (uw.act == A_RD_OB);
  assign ks_raddr = (uw.act == A_RD_OA) ? oa_r : ob_r;

  assign enc_bad = (a_r >= NLETTERS) || (b_r >= NLETTERS) || (fill_r < NCELLS);
  assign fa      = fold_letter(a_r);
  assign fb      = fold_letter(b_r);

  assign ra = cell_row(ca_r);
  assign ka = cell_col(ca_r);
  assign rb = cell_row(cb_r);
  assign kb = cell_col(cb_r);

  always_comb begin
    pc_nxt         = pc_r;
    fill_nxt       = fill_r;
    placed_nxt     = placed_r;
    v_nxt          = v_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    ca_nxt         = ca_r;
    cb_nxt         = cb_r;
    oa_nxt         = oa_r;
    ob_nxt         = ob_r;
    cf_nxt         = cf_r;
    out_valid_nxt  = 1'b0;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;

    if (place_ok) begin
      fill_nxt                 = cell_t'(fill_r + 5'd1);
      placed_nxt[place_letter] = 1'b1;
    end

    unique case (uw.act)
      A_NOP, A_PLACE_KEY, A_RD_LCA, A_RD_OA: begin
      end
      A_VCLR: v_nxt = '0;
      A_PLACE_V: v_nxt = letter_t'(v_r + 5'd1);
      A_FOLD: begin
        a_nxt = fa;
        b_nxt = (fa == fb) ? ((fa == LET_X) ? LET_Q : LET_X) : fb;
      end
      A_RD_LCB: ca_nxt = lc_rdata;
      A_CAP_CB: cb_nxt = lc_rdata;
      A_CALC: begin
        if (ra == rb) begin
          oa_nxt = cell_at(ra, wrap_inc(ka));
          ob_nxt = cell_at(rb, wrap_inc(kb));
        end else if (ka == kb) begin
          oa_nxt = cell_at(wrap_inc(ra), ka);
          ob_nxt = cell_at(wrap_inc(rb), kb);
        end else begin
          oa_nxt = cell_at(ra, kb);
          ob_nxt = cell_at(rb, ka);
        end
      end
      A_RD_OB: cf_nxt = ks_rdata;
      A_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_first_nxt  = cf_r;
        out_second_nxt = ks_rdata;
      end
      default: begin
      end
    endcase

    unique case (uw.cond)
      C_NEXT: pc_nxt = step_t'(pc_r + 4'd1);
      C_GOTO: pc_nxt = uw.target;
      C_DISPATCH: begin
        if (start) begin
          a_nxt = in_first_letter;
          b_nxt = in_second_letter;
          unique case (op_t'(in_opcode))
            OP_ADD:     pc_nxt = S_ADD;
            OP_FINISH:  pc_nxt = S_FIN;
            OP_ENCRYPT: pc_nxt = S_ENC;
            OP_NONE:    pc_nxt = S_IDLE;
            default:    pc_nxt = S_IDLE;
          endcase
        end
      end
      C_VLOOP: pc_nxt = (v_r == LET_LAST) ? uw.target : pc_r;
      C_ENCCHK: pc_nxt = enc_bad ? uw.target : step_t'(pc_r + 4'd1);
      default: pc_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      fill_r      <= '0;
      placed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      fill_r      <= fill_nxt;
      placed_r    <= placed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r          <= v_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    ca_r         <= ca_nxt;
    cb_r         <= cb_nxt;
    oa_r         <= oa_nxt;
    ob_r         <= ob_nxt;
    cf_r         <= cf_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
  end

  assign busy              = (pc_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_cipher_first  = out_first_r;
  assign out_cipher_second = out_second_r;

`ifndef SYNTH
  a_pulse_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NCELLS)
    else $error("fill position beyond square");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(placed_r) == 32'(fill_r))
    else $error("placed letters disagree with fill position");

  a_result_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> fill_r == NCELLS)
    else $error("result before key square full");

  a_no_j: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_first_r != LET_J) && (out_second_r != LET_J))
    else $error("cipher letter J");
`endif

endmodule

// File: tb/sv/tb_playfair_digraph_encrypt.sv
// Self-checking testbench for the Playfair digraph encryptor: key build, fill and pair encryption.
module tb_playfair_digraph_encrypt;
  timeunit 1ns;
  timeprecision 1ps;

  import pfenc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 420;

  class cipher_scoreboard;
    letter_t     square[CELLS];
    cell_t       cell_of[LETTERS];
    bit          placed[LETTERS];
    int unsigned filled;
    letter_t     want_first[$];
    letter_t     want_second[$];
    int          errors;

    function new();
      filled = 0;
      errors = 0;
      foreach (placed[i]) placed[i] = 1'b0;
    endfunction

    function letter_t fold(letter_t v);
      return (v == LET_J) ? LET_I : v;
    endfunction

    function void place(letter_t v);
      if (v >= NLETTERS || placed[v] || filled >= CELLS) return;
      square[filled] = v;
      cell_of[v] = cell_t'(filled);
      placed[v] = 1'b1;
      filled++;
    endfunction

    function void note(op_t op, letter_t a, letter_t b);
      int ca, cb, ra, rb, ka, kb, oa, ob;
      letter_t x, y;
      case (op)
        OP_ADD: begin
          if (a < NLETTERS) place(fold(a));
        end
        OP_FINISH: begin
          for (int v = 0; v < LETTERS; v++)
            if (letter_t'(v) != LET_J) place(letter_t'(v));
        end
        OP_ENCRYPT: begin
          if (a < NLETTERS && b < NLETTERS && filled == CELLS) begin
            x = fold(a);
            y = fold(b);
            if (x == y) y = (x == LET_X) ? LET_Q : LET_X;
            ca = cell_of[x];
            cb = cell_of[y];
            ra = ca / SIDE;
            ka = ca % SIDE;
            rb = cb / SIDE;
            kb = cb % SIDE;
            if (ra == rb) begin
              oa = ra * SIDE + (ka + 1) % SIDE;
              ob = rb * SIDE + (kb + 1) % SIDE;
            end else if (ka == kb) begin
              oa = ((ra + 1) % SIDE) * SIDE + ka;
              ob = ((rb + 1) % SIDE) * SIDE + kb;
            end else begin
              oa = ra * SIDE + kb;
              ob = rb * SIDE + ka;
            end
            want_first.push_back(square[oa]);
            want_second.push_back(square[ob]);
          end
        end
        default: ;
      endcase
    endfunction

    function void check(letter_t f, letter_t s);
      letter_t ef, es;
      if (want_first.size() == 0) begin
        $display("%0t: unexpected cipher pair, expected none, actual %0d %0d", $time, f, s);
        errors++;
        return;
      end
      ef = want_first.pop_front();
      es = want_second.pop_front();
      if (f !== ef) begin
        $display("%0t: cipher_first expected %0d actual %0d", $time, ef, f);
        errors++;
      end
      if (s !== es) begin
        $display("%0t: cipher_second expected %0d actual %0d", $time, es, s);
        errors++;
      end
    endfunction

    function int pending();
      return want_first.size();
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  logic [1:0] in_opcode;
  letter_t in_first_letter;
  letter_t in_second_letter;
  logic    out_valid;
  letter_t out_cipher_first;
  letter_t out_cipher_second;

  cipher_scoreboard sb;
  int unsigned      cycles;
  int               items_sent;

  playfair_digraph_encrypt dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_first_letter  (in_first_letter),
    .in_second_letter (in_second_letter),
    .out_valid        (out_valid),
    .out_cipher_first (out_cipher_first),
    .out_cipher_second(out_cipher_second)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note(op_t'(in_opcode), in_first_letter, in_second_letter);
      if (out_valid) sb.check(out_cipher_first, out_cipher_second);
    end
  end

  task automatic send_item(op_t op, letter_t a, letter_t b);
    @(negedge clk);
    in_opcode        <= op;
    in_first_letter  <= a;
    in_second_letter <= b;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic rest(int n);
    if (n > 0) begin
      @(negedge clk);
      start            <= 1'b0;
      in_opcode        <= 2'($urandom);
      in_first_letter  <= letter_t'($urandom);
      in_second_letter <= letter_t'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_and_rest(op_t op, letter_t a, letter_t b);
    send_item(op, a, b);
    rest(pick_gap());
  endtask

  function automatic letter_t any_letter();
    return letter_t'($urandom_range(0, LETTERS - 1));
  endfunction

  function automatic letter_t any_code();
    return letter_t'($urandom_range(0, 31));
  endfunction

  initial begin
    int r;
    sb               = new();
    cycles           = 0;
    items_sent       = 0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_opcode        = OP_NONE;
    in_first_letter  = '0;
    in_second_letter = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    send_and_rest(OP_ENCRYPT, 5'd0, 5'd1);
    send_and_rest(OP_ADD, LET_J, 5'd0);
    send_and_rest(OP_ADD, 5'd31, 5'd31);
    send_and_rest(OP_ADD, LET_I, 5'd0);
    send_and_rest(OP_NONE, 5'd0, 5'd0);
    send_and_rest(OP_ADD, LET_X, 5'd0);
    send_and_rest(OP_ADD, LET_LAST, 5'd0);
    send_and_rest(OP_ADD, 5'd0, 5'd0);
    repeat ($urandom_range(2, 10)) send_and_rest(OP_ADD, any_code(), any_code());
    send_and_rest(OP_ENCRYPT, 5'd2, 5'd3);
    send_and_rest(OP_FINISH, 5'd0, 5'd0);
    send_and_rest(OP_FINISH, 5'd31, 5'd31);
    send_and_rest(OP_ADD, 5'd5, 5'd0);
    send_and_rest(OP_ENCRYPT, sb.square[0], sb.square[4]);
    send_and_rest(OP_ENCRYPT, sb.square[8], sb.square[6]);
    send_and_rest(OP_ENCRYPT, sb.square[2], sb.square[22]);
    send_and_rest(OP_ENCRYPT, sb.square[13], sb.square[3]);
    send_and_rest(OP_ENCRYPT, sb.square[0], sb.square[24]);
    send_and_rest(OP_ENCRYPT, sb.square[24], sb.square[0]);
    send_and_rest(OP_ENCRYPT, 5'd0, 5'd0);
    send_and_rest(OP_ENCRYPT, LET_X, LET_X);
    send_and_rest(OP_ENCRYPT, LET_J, LET_I);
    send_and_rest(OP_ENCRYPT, LET_J, LET_J);
    send_and_rest(OP_ENCRYPT, LET_LAST, LET_LAST);
    send_and_rest(OP_ENCRYPT, 5'd31, 5'd4);
    send_and_rest(OP_ENCRYPT, 5'd4, NLETTERS);

    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_and_rest(OP_ENCRYPT, any_letter(), any_letter());
      end else if (r < 85) begin
        send_and_rest(OP_ENCRYPT, any_code(), any_code());
      end else if (r < 92) begin
        send_and_rest(OP_ADD, any_code(), any_code());
      end else if (r < 96) begin
        send_and_rest(OP_FINISH, any_code(), any_code());
      end else begin
        send_and_rest(OP_NONE, any_code(), any_code());
      end
      items_sent++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
